// File: rtl/core/ncts_pkg.sv
// Shared types and constants for the NAND chunk tag stream sizer.
package ncts_pkg;

   // Field and register widths
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned PAGE_W      = 14;
   localparam int unsigned STRIDE_W    = 14;
   localparam int unsigned GAP_W       = 16;
   localparam int unsigned MAXIDX_W    = 25;
   localparam int unsigned LCI_W       = 25;
   localparam int unsigned COUNT_W     = LCI_W + 1;
   localparam int unsigned RUN_W       = 17;
   localparam int unsigned BYTES_W     = 39;
   localparam int unsigned CSR_DATA_W  = 25;
   localparam int unsigned CSR_INDEX_W = 2;

   // Queue between classifier and walk
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned QCNT_W      = 3;

   // Tag and header checks
   localparam logic [WORD_W-1:0] OBJ_ALL_ONES = 32'hffff_ffff;
   localparam logic [WORD_W-1:0] ID_LIMIT     = 32'h0010_0000;
   localparam int unsigned       HDR_FLAG_BIT = 31;
   localparam int unsigned       PARENT_W     = 28;
   localparam logic [WORD_W-1:0] HDR_TYPE_MIN = 32'd1;
   localparam logic [WORD_W-1:0] HDR_TYPE_MAX = 32'd5;

   // Register reset values
   localparam logic [PAGE_W-1:0]   PAGE_BYTES_RST   = 14'd2048;
   localparam logic [STRIDE_W-1:0] CHUNK_STRIDE_RST = 14'd2112;
   localparam logic [GAP_W-1:0]    GAP_CAP_RST      = 16'd2048;
   localparam logic [MAXIDX_W-1:0] MAX_INDEX_RST    = 25'd20000000;

   typedef enum logic [1:0] {
      CLASS_CONTENT = 2'd0,
      CLASS_ERASED  = 2'd1,
      CLASS_BROKEN  = 2'd2
   } chunk_class_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAGE_BYTES      = 2'd0,
      CSR_CHUNK_STRIDE    = 2'd1,
      CSR_ERASED_GAP      = 2'd2,
      CSR_MAX_CHUNK_INDEX = 2'd3
   } csr_index_type;

   // One classified chunk waiting for the walk
   typedef struct packed {
      chunk_class_type cls;
      logic            first;
      logic            last;
   } chunk_entry_type;

   // Walk limits
   typedef struct packed {
      logic [GAP_W-1:0]    gap_cap;
      logic [MAXIDX_W-1:0] max_index;
   } walk_cfg_type;

endpackage

// File: rtl/core/ncts_front.sv
// Front end: classify each chunk from its tag and header words.
module ncts_front (
   input  logic                           req_tag_present,
   input  logic [ncts_pkg::WORD_W-1:0]    req_tag_object_id,
   input  logic [ncts_pkg::WORD_W-1:0]    req_tag_chunk_id,
   input  logic [ncts_pkg::WORD_W-1:0]    req_tag_byte_count,
   input  logic [ncts_pkg::WORD_W-1:0]    req_header_type,
   input  logic [ncts_pkg::WORD_W-1:0]    req_header_parent,
   input  logic                           req_first_chunk,
   input  logic                           req_last_chunk,
   input  logic [ncts_pkg::PAGE_W-1:0]    page_bytes,
   output ncts_pkg::chunk_entry_type      entry
);

   logic is_header;
   logic hdr_flag;
   logic hdr_ok;
   logic parent_ok;
   logic data_ok;
   ncts_pkg::chunk_class_type cls;

   // Header checks
   assign hdr_flag  = req_tag_chunk_id[ncts_pkg::HDR_FLAG_BIT];
   assign is_header = (req_tag_chunk_id == '0) || hdr_flag;
   assign hdr_ok    = (req_header_type >= ncts_pkg::HDR_TYPE_MIN) &&
                      (req_header_type <= ncts_pkg::HDR_TYPE_MAX) &&
                      (req_header_parent <= ncts_pkg::ID_LIMIT);
   assign parent_ok = !hdr_flag ||
                      (ncts_pkg::WORD_W'(req_tag_chunk_id[ncts_pkg::PARENT_W-1:0]) ==
                       req_header_parent);

   // Data chunk checks
   assign data_ok = (req_tag_byte_count <= ncts_pkg::WORD_W'(page_bytes)) &&
                    (req_tag_chunk_id <= ncts_pkg::ID_LIMIT);

   // Pick the class
   always_comb begin
      if (!req_tag_present) begin
         cls = ncts_pkg::CLASS_BROKEN;
      end else if ((req_tag_object_id == '0) ||
                   (req_tag_object_id == ncts_pkg::OBJ_ALL_ONES)) begin
         cls = ncts_pkg::CLASS_ERASED;
      end else if (is_header) begin
         cls = (hdr_ok && parent_ok) ? ncts_pkg::CLASS_CONTENT : ncts_pkg::CLASS_BROKEN;
      end else begin
         cls = data_ok ? ncts_pkg::CLASS_CONTENT : ncts_pkg::CLASS_BROKEN;
      end
   end

   assign entry.cls   = cls;
   assign entry.first = req_first_chunk;
   assign entry.last  = req_last_chunk;

endmodule

// File: rtl/core/ncts_queue.sv
// Short queue between the classifier and the walk.
module ncts_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ncts_pkg::chunk_entry_type  push_data,
   output logic                       not_full,
   input  logic                       pop,
   output logic                       not_empty,
   output ncts_pkg::chunk_entry_type  pop_data
);

   ncts_pkg::chunk_entry_type         mem_ff [ncts_pkg::QUEUE_DEPTH];
   logic [ncts_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ncts_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ncts_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign not_full  = (count_ff != ncts_pkg::QCNT_W'(ncts_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/ncts_back.sv
// Back end: walk state update, then image size multiply into the result register.
module ncts_back #(
   parameter int unsigned INDEX_BITS = 25
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  ncts_pkg::chunk_entry_type       in_entry,
   output logic                            in_ready,
   input  ncts_pkg::walk_cfg_type          walk_cfg,
   input  logic [ncts_pkg::STRIDE_W-1:0]   chunk_stride,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_chunk_class,
   output logic                            rsp_walk_done,
   output logic [ncts_pkg::BYTES_W-1:0]    rsp_image_bytes
);

   localparam int unsigned CMP_W  = (INDEX_BITS > ncts_pkg::MAXIDX_W) ?
                                    INDEX_BITS : ncts_pkg::MAXIDX_W;
   localparam int unsigned PROD_W = ncts_pkg::COUNT_W + ncts_pkg::STRIDE_W;

   // Walk state
   logic [INDEX_BITS-1:0]              chunk_index_ff, chunk_index_in;
   logic [ncts_pkg::LCI_W-1:0]         last_content_ff, last_content_in;
   logic [ncts_pkg::RUN_W-1:0]         erased_run_ff, erased_run_in;
   logic                               seen_content_ff, seen_content_in;
   logic                               finished_ff, finished_in;

   // Walk result stage
   logic                               walk_valid_ff, walk_valid_in;
   ncts_pkg::chunk_class_type          walk_class_ff;
   logic                               walk_done_ff;
   logic [ncts_pkg::COUNT_W-1:0]       walk_count_ff, walk_count_in;

   // Output stage
   logic                               out_valid_ff, out_valid_in;
   logic [1:0]                         out_class_ff;
   logic                               out_done_ff;
   logic [ncts_pkg::BYTES_W-1:0]       out_bytes_ff;
   logic [PROD_W-1:0]                  product;

   // Walk state after a possible restart
   logic [INDEX_BITS-1:0]              cur_index;
   logic [ncts_pkg::LCI_W-1:0]         cur_last;
   logic [ncts_pkg::RUN_W-1:0]         cur_run;
   logic                               cur_seen;
   logic                               cur_fin;

   logic                               out_ready;
   logic                               take;

   assign out_ready = !out_valid_ff || rsp_ready;
   assign in_ready  = !walk_valid_ff || out_ready;
   assign take      = in_valid && in_ready;

   // Restart the walk on a first chunk
   always_comb begin
      if (in_entry.first) begin
         cur_index = '0;
         cur_last  = '0;
         cur_run   = '0;
         cur_seen  = 1'b0;
         cur_fin   = 1'b0;
      end else begin
         cur_index = chunk_index_ff;
         cur_last  = last_content_ff;
         cur_run   = erased_run_ff;
         cur_seen  = seen_content_ff;
         cur_fin   = finished_ff;
      end
   end

   // Advance the walk by one chunk
   always_comb begin
      chunk_index_in  = cur_index;
      last_content_in = cur_last;
      erased_run_in   = cur_run;
      seen_content_in = cur_seen;
      finished_in     = cur_fin;
      if (!cur_fin) begin
         case (in_entry.cls)
            ncts_pkg::CLASS_CONTENT: begin
               last_content_in = ncts_pkg::LCI_W'(cur_index);
               seen_content_in = 1'b1;
               erased_run_in   = '0;
            end
            ncts_pkg::CLASS_ERASED: begin
               if (cur_seen) begin
                  if (cur_run != '1) begin
                     erased_run_in = cur_run + 1'b1;
                  end
                  if (erased_run_in > ncts_pkg::RUN_W'(walk_cfg.gap_cap)) begin
                     finished_in = 1'b1;
                  end
               end
            end
            default: begin
               finished_in = 1'b1;
            end
         endcase
         if ((CMP_W'(cur_index) >= CMP_W'(walk_cfg.max_index)) || in_entry.last) begin
            finished_in = 1'b1;
         end
         chunk_index_in = cur_index + 1'b1;
      end
      walk_count_in = ncts_pkg::COUNT_W'(last_content_in) + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_index_ff  <= '0;
         last_content_ff <= '0;
         erased_run_ff   <= '0;
         seen_content_ff <= 1'b0;
         finished_ff     <= 1'b0;
      end else if (take) begin
         chunk_index_ff  <= chunk_index_in;
         last_content_ff <= last_content_in;
         erased_run_ff   <= erased_run_in;
         seen_content_ff <= seen_content_in;
         finished_ff     <= finished_in;
      end
   end

   // Hold the walk result until the multiply stage takes it
   always_comb begin
      walk_valid_in = walk_valid_ff;
      if (take) begin
         walk_valid_in = 1'b1;
      end else if (out_ready) begin
         walk_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_valid_ff <= 1'b0;
      end else begin
         walk_valid_ff <= walk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         walk_class_ff <= in_entry.cls;
         walk_done_ff  <= finished_in;
         walk_count_ff <= walk_count_in;
      end
   end

   // Scale the chunk count by the stride
   assign product = PROD_W'(walk_count_ff) * PROD_W'(chunk_stride);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_ready) begin
         out_valid_in = walk_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && walk_valid_ff) begin
         out_class_ff <= walk_class_ff;
         out_done_ff  <= walk_done_ff;
         out_bytes_ff <= product[ncts_pkg::BYTES_W-1:0];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_chunk_class = out_class_ff;
   assign rsp_walk_done   = out_done_ff;
   assign rsp_image_bytes = out_bytes_ff;

endmodule

// File: rtl/core/nand_chunk_tag_stream_sizer.sv
// Top level of the NAND chunk tag stream sizer: registers, classifier, queue and walk.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_ready  | tag words, header words, first/last flags
//   rsp     | out       | rsp_valid/rsp_ready  | chunk class, walk done, image bytes
//   csr     | in        | csr_write            | csr_index, csr_wdata
//
// One chunk per cycle sustained while rsp is not stalled. A chunk is classified on entry
// and queued (4 deep); from the queue the walk update registers into the walk result stage,
// and the stride multiply into the output stage that drives rsp_valid. Synchronous reset clears
// the walk and the queue and loads the register defaults. A stalled rsp fills the output and
// walk stages, then the queue, and only then drops req_ready.
module nand_chunk_tag_stream_sizer #(
   parameter int unsigned INDEX_BITS = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_tag_present,
   input  logic [ncts_pkg::WORD_W-1:0]         req_tag_object_id,
   input  logic [ncts_pkg::WORD_W-1:0]         req_tag_chunk_id,
   input  logic [ncts_pkg::WORD_W-1:0]         req_tag_byte_count,
   input  logic [ncts_pkg::WORD_W-1:0]         req_header_type,
   input  logic [ncts_pkg::WORD_W-1:0]         req_header_parent,
   input  logic                                req_first_chunk,
   input  logic                                req_last_chunk,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_chunk_class,
   output logic                                rsp_walk_done,
   output logic [ncts_pkg::BYTES_W-1:0]        rsp_image_bytes,
   input  logic                                csr_write,
   input  logic [ncts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ncts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [ncts_pkg::PAGE_W-1:0]     page_bytes_ff;
   logic [ncts_pkg::STRIDE_W-1:0]   chunk_stride_ff;
   logic [ncts_pkg::GAP_W-1:0]      gap_cap_ff;
   logic [ncts_pkg::MAXIDX_W-1:0]   max_index_ff;

   ncts_pkg::chunk_entry_type       front_entry;
   ncts_pkg::chunk_entry_type       queue_entry;
   ncts_pkg::walk_cfg_type          walk_cfg;
   logic                            queue_not_full;
   logic                            queue_not_empty;
   logic                            back_ready;
   logic                            push;
   logic                            pop;

   // Load configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_bytes_ff   <= ncts_pkg::PAGE_BYTES_RST;
         chunk_stride_ff <= ncts_pkg::CHUNK_STRIDE_RST;
         gap_cap_ff      <= ncts_pkg::GAP_CAP_RST;
         max_index_ff    <= ncts_pkg::MAX_INDEX_RST;
      end else if (csr_write) begin
         unique case (ncts_pkg::csr_index_type'(csr_index))
            ncts_pkg::CSR_PAGE_BYTES: begin
               page_bytes_ff <= csr_wdata[ncts_pkg::PAGE_W-1:0];
            end
            ncts_pkg::CSR_CHUNK_STRIDE: begin
               chunk_stride_ff <= csr_wdata[ncts_pkg::STRIDE_W-1:0];
            end
            ncts_pkg::CSR_ERASED_GAP: begin
               gap_cap_ff <= csr_wdata[ncts_pkg::GAP_W-1:0];
            end
            ncts_pkg::CSR_MAX_CHUNK_INDEX: begin
               max_index_ff <= csr_wdata[ncts_pkg::MAXIDX_W-1:0];
            end
            default: begin
               page_bytes_ff <= page_bytes_ff;
            end
         endcase
      end
   end

   assign walk_cfg.gap_cap   = gap_cap_ff;
   assign walk_cfg.max_index = max_index_ff;

   assign req_ready = queue_not_full;
   assign push      = req_valid && queue_not_full;
   assign pop       = queue_not_empty && back_ready;

   ncts_front u_front (
      .req_tag_present    (req_tag_present),
      .req_tag_object_id  (req_tag_object_id),
      .req_tag_chunk_id   (req_tag_chunk_id),
      .req_tag_byte_count (req_tag_byte_count),
      .req_header_type    (req_header_type),
      .req_header_parent  (req_header_parent),
      .req_first_chunk    (req_first_chunk),
      .req_last_chunk     (req_last_chunk),
      .page_bytes         (page_bytes_ff),
      .entry              (front_entry)
   );

   ncts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_entry),
      .not_full  (queue_not_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_data  (queue_entry)
   );

   ncts_back #(
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (queue_not_empty),
      .in_entry        (queue_entry),
      .in_ready        (back_ready),
      .walk_cfg        (walk_cfg),
      .chunk_stride    (chunk_stride_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_chunk_class (rsp_chunk_class),
      .rsp_walk_done   (rsp_walk_done),
      .rsp_image_bytes (rsp_image_bytes)
   );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the NAND chunk tag stream sizer, with its own walk predictor.
module tb_top;
   import ncts_pkg::*;

   localparam int unsigned WALK_INDEX_BITS = 25;
   localparam int unsigned PHASES          = 8;
   localparam int unsigned PHASE_ITEMS     = 66;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned WATCHDOG_LIMIT  = 2000;

   typedef struct {
      logic              present;
      logic [WORD_W-1:0] obj;
      logic [WORD_W-1:0] cid;
      logic [WORD_W-1:0] cnt;
      logic [WORD_W-1:0] typ;
      logic [WORD_W-1:0] par;
      logic              first_flag;
      logic              last_flag;
   } chunk_item_type;

   typedef struct {
      chunk_class_type    cls;
      logic               done;
      logic [BYTES_W-1:0] bytes;
   } chunk_result_type;

   typedef struct {
      chunk_item_type   item;
      logic             typed;
      chunk_result_type result;
   } directed_row_type;

   typedef enum logic [2:0] {
      GEN_HEADER,
      GEN_DATA,
      GEN_ERASED,
      GEN_BROKEN,
      GEN_NOISE
   } chunk_gen_kind_type;

   // DUT ports, all inputs known from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_tag_present = 1'b0;
   logic [WORD_W-1:0]      req_tag_object_id = '0;
   logic [WORD_W-1:0]      req_tag_chunk_id = '0;
   logic [WORD_W-1:0]      req_tag_byte_count = '0;
   logic [WORD_W-1:0]      req_header_type = '0;
   logic [WORD_W-1:0]      req_header_parent = '0;
   logic                   req_first_chunk = 1'b0;
   logic                   req_last_chunk = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_chunk_class;
   logic                   rsp_walk_done;
   logic [BYTES_W-1:0]     rsp_image_bytes;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor copy of the registers and the walk
   logic [PAGE_W-1:0]          cfg_page = PAGE_BYTES_RST;
   logic [STRIDE_W-1:0]        cfg_stride = CHUNK_STRIDE_RST;
   logic [GAP_W-1:0]           cfg_gap = GAP_CAP_RST;
   logic [MAXIDX_W-1:0]        cfg_max = MAX_INDEX_RST;
   logic [WALK_INDEX_BITS-1:0] walk_pos = '0;
   logic [LCI_W-1:0]           last_content_pos = '0;
   logic [RUN_W-1:0]           erased_count = '0;
   logic                       content_seen = 1'b0;
   logic                       walk_over = 1'b0;

   chunk_result_type expected_sizes[$];
   directed_row_type directed_rows[$];

   logic        stall_free = 1'b0;
   int unsigned error_count = 0;
   int unsigned chunks_sent = 0;
   int unsigned results_checked = 0;
   int unsigned walk_ends_seen = 0;
   int unsigned idle_cycles = 0;

   nand_chunk_tag_stream_sizer #(
      .INDEX_BITS(WALK_INDEX_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_tag_present(req_tag_present),
      .req_tag_object_id(req_tag_object_id),
      .req_tag_chunk_id(req_tag_chunk_id),
      .req_tag_byte_count(req_tag_byte_count),
      .req_header_type(req_header_type),
      .req_header_parent(req_header_parent),
      .req_first_chunk(req_first_chunk),
      .req_last_chunk(req_last_chunk),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_chunk_class(rsp_chunk_class),
      .rsp_walk_done(rsp_walk_done),
      .rsp_image_bytes(rsp_image_bytes),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Sort one chunk from its tag and header words
   function automatic chunk_class_type classify_chunk(input chunk_item_type c);
      if (!c.present)
         return CLASS_BROKEN;
      if (c.obj == '0 || c.obj == OBJ_ALL_ONES)
         return CLASS_ERASED;
      if (c.cid == '0 || c.cid[HDR_FLAG_BIT]) begin
         if (c.typ < HDR_TYPE_MIN || c.typ > HDR_TYPE_MAX || c.par > ID_LIMIT)
            return CLASS_BROKEN;
         if (c.cid[HDR_FLAG_BIT] && {4'd0, c.cid[PARENT_W-1:0]} != c.par)
            return CLASS_BROKEN;
         return CLASS_CONTENT;
      end
      if (c.cnt <= {18'd0, cfg_page} && c.cid <= ID_LIMIT)
         return CLASS_CONTENT;
      return CLASS_BROKEN;
   endfunction

   // Advance the walk by one chunk and work out its result
   task automatic walk_and_size(input chunk_item_type c, output chunk_result_type r);
      logic [63:0] product;
      r.cls = classify_chunk(c);
      if (c.first_flag) begin
         walk_pos = '0;
         last_content_pos = '0;
         erased_count = '0;
         content_seen = 1'b0;
         walk_over = 1'b0;
      end
      if (!walk_over) begin
         case (r.cls)
            CLASS_CONTENT: begin
               last_content_pos = walk_pos;
               content_seen = 1'b1;
               erased_count = '0;
            end
            CLASS_ERASED: begin
               // erased chunks ahead of the first content do not count
               if (content_seen) begin
                  if (erased_count != '1)
                     erased_count = erased_count + 1'b1;
                  if (erased_count > {1'b0, cfg_gap})
                     walk_over = 1'b1;
               end
            end
            default: walk_over = 1'b1;
         endcase
         if (walk_pos >= cfg_max || c.last_flag)
            walk_over = 1'b1;
         walk_pos = walk_pos + 1'b1;
      end
      product = ({39'd0, last_content_pos} + 64'd1) * {50'd0, cfg_stride};
      r.done = walk_over;
      r.bytes = product[BYTES_W-1:0];
   endtask

   // Pick an idle gap: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (stall_free)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Build one chunk of the given kind with random content
   function automatic chunk_item_type make_chunk(input chunk_gen_kind_type kind,
                                                 input logic first_flag,
                                                 input logic last_flag);
      chunk_item_type c;
      c.present = 1'b1;
      c.obj = $urandom;
      if (c.obj == '0 || c.obj == OBJ_ALL_ONES)
         c.obj = 32'h1;
      c.cid = $urandom;
      c.cnt = $urandom;
      c.typ = $urandom;
      c.par = $urandom;
      c.first_flag = first_flag;
      c.last_flag = last_flag;
      case (kind)
         GEN_HEADER: begin
            c.typ = $urandom_range(1, 5);
            c.par = $urandom_range(0, ID_LIMIT);
            if ($urandom_range(0, 2) == 0) begin
               c.cid = '0;
            end else begin
               c.cid[HDR_FLAG_BIT] = 1'b1;
               c.cid[PARENT_W-1:0] = c.par[PARENT_W-1:0];
            end
         end
         GEN_DATA: begin
            c.cid = $urandom_range(1, ID_LIMIT);
            c.cnt = ($urandom_range(0, 3) == 0) ? {18'd0, cfg_page}
                                                : $urandom_range(0, cfg_page);
         end
         GEN_ERASED: c.obj = $urandom_range(0, 1) ? '0 : OBJ_ALL_ONES;
         GEN_BROKEN: begin
            case ($urandom_range(0, 5))
               0: c.present = 1'b0;
               1: begin
                  c.cid = '0;
                  c.par = $urandom_range(0, ID_LIMIT);
                  c.typ = $urandom_range(0, 1) ? '0 : $urandom_range(6, 32'hffff_ffff);
               end
               2: begin
                  c.cid = '0;
                  c.typ = $urandom_range(1, 5);
                  c.par = $urandom_range(ID_LIMIT + 1, 32'hffff_ffff);
               end
               3: begin
                  // header whose parent field disagrees in one bit
                  c.typ = $urandom_range(1, 5);
                  c.par = $urandom_range(0, ID_LIMIT);
                  c.cid[HDR_FLAG_BIT] = 1'b1;
                  c.cid[PARENT_W-1:0] = c.par[PARENT_W-1:0] ^ (28'd1 << $urandom_range(0, 27));
               end
               4: begin
                  c.cid = $urandom_range(1, ID_LIMIT);
                  c.cnt = $urandom_range({18'd0, cfg_page} + 32'd1, 32'hffff_ffff);
               end
               default: begin
                  c.cid = $urandom_range(ID_LIMIT + 1, 32'h7fff_ffff);
                  c.cnt = $urandom_range(0, cfg_page);
               end
            endcase
         end
         default: begin
            c.present = ($urandom_range(0, 7) != 0);
            c.first_flag = ($urandom_range(0, 5) == 0);
            c.last_flag = ($urandom_range(0, 5) == 0);
         end
      endcase
      return c;
   endfunction

   // Drive one transaction; record its expected result when accepted
   task automatic send_chunk(input chunk_item_type c, input logic typed,
                             input chunk_result_type given);
      int unsigned      gap;
      chunk_result_type predicted;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tag_present <= c.present;
      req_tag_object_id <= c.obj;
      req_tag_chunk_id <= c.cid;
      req_tag_byte_count <= c.cnt;
      req_header_type <= c.typ;
      req_header_parent <= c.par;
      req_first_chunk <= c.first_flag;
      req_last_chunk <= c.last_flag;
      do @(posedge clock); while (!req_ready);
      walk_and_size(c, predicted);
      if (typed)
         expected_sizes.insert(expected_sizes.size(), given);
      else
         expected_sizes.insert(expected_sizes.size(), predicted);
      chunks_sent++;
   endtask

   // Drop valid and wait for every expected result, then let the pipe go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_sizes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers, one per cycle, and mirror them
   task automatic load_registers(input logic [PAGE_W-1:0] page,
                                 input logic [STRIDE_W-1:0] stride,
                                 input logic [GAP_W-1:0] gap,
                                 input logic [MAXIDX_W-1:0] max_idx);
      csr_write <= 1'b1;
      csr_index <= CSR_PAGE_BYTES;
      csr_wdata <= CSR_DATA_W'(page);
      @(posedge clock);
      csr_index <= CSR_CHUNK_STRIDE;
      csr_wdata <= CSR_DATA_W'(stride);
      @(posedge clock);
      csr_index <= CSR_ERASED_GAP;
      csr_wdata <= CSR_DATA_W'(gap);
      @(posedge clock);
      csr_index <= CSR_MAX_CHUNK_INDEX;
      csr_wdata <= CSR_DATA_W'(max_idx);
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_page = page;
      cfg_stride = stride;
      cfg_gap = gap;
      cfg_max = max_idx;
   endtask

   task automatic add_row(input logic present, input logic [WORD_W-1:0] obj, cid, cnt,
                          input logic [WORD_W-1:0] typ, par, input logic first_flag,
                          input logic last_flag, input logic typed,
                          input chunk_class_type cls, input logic done,
                          input logic [BYTES_W-1:0] bytes);
      directed_row_type row;
      row.item = '{present, obj, cid, cnt, typ, par, first_flag, last_flag};
      row.typed = typed;
      row.result = '{cls, done, bytes};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Stimulus: directed rows at reset defaults, then random walks per register setting
   initial begin
      chunk_gen_kind_type kind;
      int unsigned        sent;
      int unsigned        walk_len;
      int unsigned        roll;
      logic [PAGE_W-1:0]   page;
      logic [STRIDE_W-1:0] stride;
      logic [GAP_W-1:0]    gap;
      logic [MAXIDX_W-1:0] max_idx;

      // reset-default walk: page 2048, stride 2112
      add_row(1'b0, 32'h1, 32'h1, 32'h0, 32'h1, 32'h0, 1'b0, 1'b0, 1'b1, CLASS_BROKEN, 1'b1,
              39'd2112);
      add_row(1'b1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 1'b1, 1'b0, 1'b1, CLASS_ERASED, 1'b0,
              39'd2112);
      add_row(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              1'b0, 1'b0, 1'b1, CLASS_ERASED, 1'b0, 39'd2112);
      add_row(1'b1, 32'h1, 32'h0, 32'hffff_ffff, 32'h1, 32'h0, 1'b0, 1'b0, 1'b1,
              CLASS_CONTENT, 1'b0, 39'd6336);
      add_row(1'b1, 32'h1234_5678, 32'h8010_0000, 32'h0, 32'h5, 32'h0010_0000, 1'b0, 1'b0,
              1'b1, CLASS_CONTENT, 1'b0, 39'd8448);
      add_row(1'b1, 32'hffff_fffe, 32'h0010_0000, 32'd2048, 32'h0, 32'hffff_ffff, 1'b0, 1'b0,
              1'b1, CLASS_CONTENT, 1'b0, 39'd10560);
      add_row(1'b1, 32'h2, 32'h1, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1, CLASS_CONTENT, 1'b0,
              39'd12672);
      add_row(1'b1, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1, CLASS_ERASED, 1'b0,
              39'd12672);
      add_row(1'b1, 32'h1, 32'h1, 32'd2049, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1, CLASS_BROKEN, 1'b1,
              39'd12672);
      // walk is over: chunks are still classed, size holds
      add_row(1'b1, 32'h3, 32'h0, 32'h0, 32'h6, 32'h0, 1'b0, 1'b0, 1'b1, CLASS_BROKEN, 1'b1,
              39'd12672);
      add_row(1'b1, 32'h3, 32'h0, 32'h0, 32'h1, 32'h0010_0001, 1'b0, 1'b0, 1'b1, CLASS_BROKEN,
              1'b1, 39'd12672);
      add_row(1'b1, 32'h3, 32'h8000_0005, 32'h0, 32'h2, 32'h6, 1'b0, 1'b0, 1'b1, CLASS_BROKEN,
              1'b1, 39'd12672);
      add_row(1'b1, 32'h3, 32'h0010_0001, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1, CLASS_BROKEN,
              1'b1, 39'd12672);
      add_row(1'b1, 32'hffff_fffe, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              1'b0, 1'b0, 1'b1, CLASS_BROKEN, 1'b1, 39'd12672);
      add_row(1'b1, 32'hffff_ffff, 32'h1, 32'h0, 32'h1, 32'h0, 1'b0, 1'b0, 1'b1, CLASS_ERASED,
              1'b1, 39'd12672);
      add_row(1'b1, 32'h7, 32'h0, 32'h0, 32'h2, 32'h0, 1'b0, 1'b0, 1'b1, CLASS_CONTENT, 1'b1,
              39'd12672);
      // new walk that is also the last chunk
      add_row(1'b1, 32'h7, 32'h0, 32'h0, 32'h3, 32'h0010_0000, 1'b1, 1'b1, 1'b1,
              CLASS_CONTENT, 1'b1, 39'd2112);
      add_row(1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0, CLASS_ERASED, 1'b0,
              39'd0);
      add_row(1'b1, 32'h9, 32'hf000_0400, 32'h0, 32'h4, 32'h400, 1'b0, 1'b0, 1'b0,
              CLASS_CONTENT, 1'b0, 39'd0);
      add_row(1'b1, 32'h8000_0000, 32'h000f_ffff, 32'h7ff, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0,
              CLASS_CONTENT, 1'b0, 39'd0);
      add_row(1'b0, 32'h9, 32'h0, 32'h0, 32'h1, 32'h0, 1'b0, 1'b1, 1'b0, CLASS_BROKEN, 1'b0,
              39'd0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_chunk(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin page = 14'd512;  stride = 14'd528;  gap = 16'd0;     max_idx = 25'd1; end
            1: begin page = 14'd8192; stride = 14'd8448; gap = 16'hffff;
                     max_idx = 25'h1ff_ffff; end
            2: begin page = '1;       stride = '1;       gap = 16'd1;     max_idx = '0;    end
            3: begin page = '0;       stride = '0;       gap = 16'd2;     max_idx = 25'd7; end
            default: begin
               page = PAGE_W'($urandom_range(512, 8192));
               stride = STRIDE_W'($urandom_range(528, 8448));
               gap = ($urandom_range(0, 3) == 0) ? GAP_W'($urandom)
                                                 : GAP_W'($urandom_range(0, 5));
               max_idx = ($urandom_range(0, 3) == 0) ?
                         MAXIDX_W'($urandom_range(1, 25'h1ff_ffff)) :
                         MAXIDX_W'($urandom_range(1, 40));
            end
         endcase
         load_registers(page, stride, gap, max_idx);
         stall_free = (ph % 4 == 3);

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
               send_chunk(make_chunk(GEN_NOISE, 1'b0, 1'b0), 1'b0, directed_rows[0].result);
               sent++;
            end else begin
               // well-formed walk: opens with first_chunk, may close with last_chunk
               walk_len = $urandom_range(1, 24);
               for (int k = 0; k < walk_len; k++) begin
                  roll = $urandom_range(0, 99);
                  if (roll < 38)
                     kind = GEN_HEADER;
                  else if (roll < 70)
                     kind = GEN_DATA;
                  else if (roll < 94)
                     kind = GEN_ERASED;
                  else
                     kind = GEN_BROKEN;
                  send_chunk(make_chunk(kind, k == 0,
                                        k == walk_len - 1 && $urandom_range(0, 1) == 1),
                             1'b0, directed_rows[0].result);
                  sent++;
               end
            end
         end
         settle();
      end

      stall_free = 1'b0;
      if (expected_sizes.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_sizes.size());
         error_count++;
      end
      $display("Sent %0d chunks over %0d register settings plus reset defaults.",
               chunks_sent, PHASES);
      $display("Checked %0d results, %0d of them with the walk ended; %0d mismatches.",
               results_checked, walk_ends_seen, error_count);
      if (error_count == 0) begin
         $display("** nand_chunk_tag_stream_sizer: PASSED **");
      end else begin
         $display("** nand_chunk_tag_stream_sizer: FAILED **");
      end
      $finish;
   end

   // Result side: random backpressure, with stall-free stretches
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Compare each accepted result transaction with the oldest expectation
   always @(posedge clock) begin : check_results
      chunk_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_sizes.size() == 0) begin
            $display("%0t: result with no transaction pending: class %0d done %0d bytes %0d",
                     $time, rsp_chunk_class, rsp_walk_done, rsp_image_bytes);
            error_count++;
         end else begin
            want = expected_sizes.pop_front();
            results_checked++;
            if (rsp_walk_done === 1'b1)
               walk_ends_seen++;
            if (rsp_chunk_class !== want.cls) begin
               $display("%0t: chunk_class mismatch, expected %0d, actual %0d",
                        $time, want.cls, rsp_chunk_class);
               error_count++;
            end
            if (rsp_walk_done !== want.done) begin
               $display("%0t: walk_done mismatch, expected %0d, actual %0d",
                        $time, want.done, rsp_walk_done);
               error_count++;
            end
            if (rsp_image_bytes !== want.bytes) begin
               $display("%0t: image_bytes mismatch, expected %0d, actual %0d",
                        $time, want.bytes, rsp_image_bytes);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, expected_sizes.size());
            $display("** nand_chunk_tag_stream_sizer: FAILED **");
            $finish;
         end
      end
   end

endmodule
